/* rtl/heightmap_triangle_height_query_assert.svh */
// Assertion macros used by the terrain height query top level.
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_ASSERT_SVH
// The consequent holds in the same cycle as the antecedent.
`define HTQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define HTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/htq_pkg.sv */
// Package of types and constants for the terrain height query block.
`timescale 1ns / 1ps
package htq_pkg;
  localparam int unsigned MaxVertsDefault = 16384;
  localparam logic signed [31:0] OutsideHeight = -32'sd6553600;
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;
  localparam logic [1:0] RegVertsPerRow = 2'd0;
  localparam logic [1:0] RegVertsPerColumn = 2'd1;
  localparam logic [1:0] RegInvCellSpacing = 2'd2;

  typedef struct packed {
    logic               command;
    logic [13:0]        entry_index;
    logic signed [31:0] entry_height;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
  } htq_in_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               in_range;
  } htq_out_t;
endpackage

/* rtl/htq_ram.sv */
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
module htq_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  output logic [Width-1:0]         rdata_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_b
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

/* rtl/heightmap_triangle_height_query.sv */
// Top level of the terrain height query: scale, cell lookup, interpolation.
// A query result strobes done once it has passed the registers of stages 1 to 6.
// Throughput: one item per cycle; busy stays low, the grid store is held in two
// copies with two read ports each so the four corners are read in the same cycle.
// A write passes wr1, wr2 and wr before it lands, on the edge where a query accepted
// with it would read; reset clears the valids, registers go to 2, 2 and 1.0.
`timescale 1ns / 1ps
`include "heightmap_triangle_height_query_assert.svh"
module heightmap_triangle_height_query #(
  parameter int MaxVerts = htq_pkg::MaxVertsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  htq_pkg::htq_in_t item_in,
  output logic             done,
  output htq_pkg::htq_out_t item_out,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import htq_pkg::*;

  localparam int AW = $clog2(MaxVerts);

  logic [8:0]  verts_per_row;
  logic [8:0]  verts_per_column;
  logic [31:0] inv_cell_spacing;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      verts_per_row <= 9'd2;
      verts_per_column <= 9'd2;
      inv_cell_spacing <= 32'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegVertsPerRow:    verts_per_row <= cfg_data[8:0];
        RegVertsPerColumn: verts_per_column <= cfg_data[8:0];
        RegInvCellSpacing: inv_cell_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Write path: three registered stages, so a write reaches the store on the
  // same edge as the corner read of a query accepted in the same slot. A query
  // then sees every earlier write and no later one.
  logic          wr1_en, wr2_en, wr_en;
  logic [AW-1:0] wr1_addr, wr2_addr, wr_addr;
  logic [31:0]   wr1_data, wr2_data, wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr1_en <= 1'b0;
      wr2_en <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      wr1_en <= accept && item_in.command == CmdWrite &&
                {18'd0, item_in.entry_index} < 32'(MaxVerts);
      wr2_en <= wr1_en;
      wr_en <= wr2_en;
    end
    wr1_addr <= AW'(item_in.entry_index);
    wr1_data <= item_in.entry_height;
    wr2_addr <= wr1_addr;
    wr2_data <= wr1_data;
    wr_addr <= wr2_addr;
    wr_data <= wr2_data;
  end

  // Stage 1: scale by the reciprocal spacing.
  logic               v1;
  logic signed [64:0] px_s, pz_s;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= accept && item_in.command == CmdQuery;
    px_s <= item_in.pos_x * $signed({1'b0, inv_cell_spacing});
    pz_s <= item_in.pos_z * $signed({1'b0, inv_cell_spacing});
  end

  // Stage 2: recenter on the grid, find the cell, check bounds.
  logic signed [49:0] sx, sz, gx, gz, colw, roww;
  logic               out2;
  logic [8:0]         ncol, nrow;
  assign sx = 50'(px_s >>> 16);
  assign sz = 50'(pz_s >>> 16);
  assign ncol = verts_per_row - 9'd1;
  assign nrow = verts_per_column - 9'd1;
  assign gx = sx + $signed({26'd0, ncol, 15'd0});
  assign gz = $signed({26'd0, nrow, 15'd0}) - sz;
  assign colw = gx >>> 16;
  assign roww = gz >>> 16;
  // A row count of zero wraps ncol/nrow to 511 and one leaves no cell; guard both explicitly.
  assign out2 = colw < 0 || roww < 0 || verts_per_row < 9'd2 || verts_per_column < 9'd2 ||
                colw >= $signed({41'd0, ncol}) || roww >= $signed({41'd0, nrow});

  logic        v2, o2;
  logic [8:0]  col2, row2;
  logic [15:0] dx2, dz2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    o2 <= out2;
    col2 <= colw[8:0];
    row2 <= roww[8:0];
    dx2 <= gx[15:0];
    dz2 <= gz[15:0];
  end

  // Stage 3: corner address.
  logic [17:0] ia_full;
  logic [18:0] id_full;
  assign ia_full = {9'd0, row2} * {9'd0, verts_per_row} + {9'd0, col2};
  assign id_full = {1'b0, ia_full} + {10'd0, verts_per_row} + 19'd1;

  logic          v3, o3;
  logic [AW-1:0] ra, rb, rc, rd;
  logic [15:0]   dx3, dz3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    o3 <= o2 || id_full >= 19'(MaxVerts);
    ra <= AW'(ia_full);
    rb <= AW'(ia_full + 18'd1);
    rc <= AW'(ia_full + {9'd0, verts_per_row});
    rd <= AW'(id_full);
    dx3 <= dx2;
    dz3 <= dz2;
  end

  // Stage 4: read the four corners, two from each copy.
  logic [31:0] qa, qb, qc, qd;
  htq_ram #(.Width(32), .Depth(MaxVerts)) u_grid_ab (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr_a(ra), .rdata_a(qa), .raddr_b(rb), .rdata_b(qb));
  htq_ram #(.Width(32), .Depth(MaxVerts)) u_grid_cd (
    .clk, .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .raddr_a(rc), .rdata_a(qc), .raddr_b(rd), .rdata_b(qd));

  logic          v4, o4;
  logic [15:0]   dx4, dz4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    o4 <= o3;
    dx4 <= dx3;
    dz4 <= dz3;
  end

  logic signed [31:0] ha, hb, hc, hd;
  assign ha = qa;
  assign hb = qb;
  assign hc = qc;
  assign hd = qd;

  // Stage 5: choose the triangle and form the differences and weights.
  logic               upper;
  assign upper = ({1'b0, dx4} + {1'b0, dz4}) < 17'h10000;

  logic               v5, o5;
  logic signed [32:0] base5, d1_5, d2_5;
  logic signed [17:0] w1_5, w2_5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    o5 <= o4;
    if (upper) begin
      base5 <= 33'(ha);
      d1_5 <= 33'(hb) - 33'(ha);
      d2_5 <= 33'(hc) - 33'(ha);
      w1_5 <= $signed({2'b00, dx4});
      w2_5 <= $signed({2'b00, dz4});
    end else begin
      base5 <= 33'(hd);
      d1_5 <= 33'(hc) - 33'(hd);
      d2_5 <= 33'(hb) - 33'(hd);
      w1_5 <= 18'sh10000 - $signed({2'b00, dx4});
      w2_5 <= 18'sh10000 - $signed({2'b00, dz4});
    end
  end

  // Stage 6: two multiplies.
  logic               v6, o6;
  logic signed [50:0] p1_6, p2_6;
  logic signed [32:0] base6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    o6 <= o5;
    p1_6 <= d1_5 * w1_5;
    p2_6 <= d2_5 * w2_5;
    base6 <= base5;
  end

  // Stage 7: sum, round, saturate.
  logic signed [52:0] hsum;
  logic signed [36:0] hr;
  logic signed [31:0] hsat;
  assign hsum = 53'($signed({base6, 16'd0})) + 53'(p1_6) + 53'(p2_6) + 53'sd32768;
  assign hr = 37'(hsum >>> 16);
  assign hsat = (hr > 37'sd2147483647) ? 32'sh7FFFFFFF :
                (hr < -37'sd2147483648) ? 32'sh80000000 : hr[31:0];

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v6;
    item_out.height <= o6 ? OutsideHeight : hsat;
    item_out.in_range <= !o6;
  end

  `HTQ_ASSERT_NEXT(a_query_flows, v1, v2, "query lost between stages 1 and 2")
  `HTQ_ASSERT_NEXT(a_done_follows, v6, done, "result strobe missing")
  `HTQ_ASSERT_SAME(a_outside_flag, done && !item_out.in_range,
                   item_out.height == OutsideHeight, "outside height wrong")
  `HTQ_ASSERT_NEXT(a_write_no_query, accept && item_in.command == CmdWrite,
                   !v1, "write item started a query")
endmodule
